// ===== src/pld_pkg.sv =====
`default_nettype none

package pld_pkg;

  // Field and register widths
  localparam int unsigned NUM_LINES  = 3;
  localparam int unsigned RAW_W      = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned MAP_W      = 6;
  localparam int unsigned PMIN_W     = 40;
  localparam int unsigned RATIO_W    = 18;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SCORE_W    = RAW_W + GAIN_W;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned LINE_W     = 2;
  localparam int unsigned STABLE_W   = 2;
  localparam int unsigned PART_W     = RATIO_W + 32;
  localparam int unsigned CMP_W      = RATIO_W + ACC_W;

  // Stability and ratio constants
  localparam logic [STABLE_W-1:0] STABLE_WINDOWS_NEEDED = 2'd3;
  localparam logic [STABLE_W-1:0] STABLE_WINDOWS_MAX    = 2'd3;
  // Ratio used when the second score is zero: 999 in Q10.8
  localparam logic [RATIO_W-1:0]  NO_RATIO_LIMIT        = 18'd255744;

  // Wire map code for a line without a candidate wire
  localparam logic [1:0] WIRE_NONE = 2'd3;

  // Line numbers
  localparam logic [LINE_W-1:0] LINE_NONE = 2'd0;
  localparam logic [LINE_W-1:0] LINE_L1   = 2'd1;
  localparam logic [LINE_W-1:0] LINE_L2   = 2'd2;
  localparam logic [LINE_W-1:0] LINE_L3   = 2'd3;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 24'd65536;
  localparam logic [MAP_W-1:0]   MAP_RESET    = 6'd36;
  localparam logic [PMIN_W-1:0]  PMIN_RESET   = '0;
  localparam logic [RATIO_W-1:0] RATIO_RESET  = 18'd512;
  localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_LINE1       = 3'd0,
    CFG_GAIN_LINE2       = 3'd1,
    CFG_GAIN_LINE3       = 3'd2,
    CFG_LINE_WIRE_MAP    = 3'd3,
    CFG_PEAK_FLOOR       = 3'd4,
    CFG_CONFIDENCE_RATIO = 3'd5,
    CFG_WINDOW_MS        = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_LOW_LOAD  = 2'd0,
    VERDICT_AMBIGUOUS = 2'd1,
    VERDICT_WEAK      = 2'd2,
    VERDICT_STABLE    = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [NUM_LINES-1:0][GAIN_W-1:0] gain;
    logic [MAP_W-1:0]                 wire_map;
    logic [PMIN_W-1:0]                peak_floor;
    logic [RATIO_W-1:0]               confidence_ratio;
    logic [TIME_W-1:0]                window_ms;
  } pld_cfg_t;

  // Window-end transaction from the accumulator to the decision pipeline
  typedef struct packed {
    logic [NUM_LINES-1:0][ACC_W-1:0] acc;
    logic                            low_load;
  } pld_event_t;

endpackage

`default_nettype wire

// ===== src/pld_if.sv =====
`default_nettype none

interface pld_frame_if;
  import pld_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_power_wire0;
  logic signed [RAW_W-1:0] raw_power_wire1;
  logic signed [RAW_W-1:0] raw_power_wire2;
  logic [TIME_W-1:0]       now_ms;

  modport source (
    output valid, raw_power_wire0, raw_power_wire1, raw_power_wire2, now_ms,
    input  ready
  );

  modport sink (
    input  valid, raw_power_wire0, raw_power_wire1, raw_power_wire2, now_ms,
    output ready
  );
endinterface

interface pld_result_if;
  import pld_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        verdict;
  logic [LINE_W-1:0] top_line;
  logic [LINE_W-1:0] next_line;

  modport source (
    output valid, verdict, top_line, next_line,
    input  ready
  );

  modport sink (
    input  valid, verdict, top_line, next_line,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/pld_cfg_regs.sv =====
`default_nettype none

module pld_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pld_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pld_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output pld_pkg::pld_cfg_t                    cfg_o
);
  import pld_pkg::*;

  pld_cfg_t cfg_q;
  pld_cfg_t cfg_d;

  // Decode the register index and truncate the write data to its width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_LINE1:       cfg_d.gain[0]          = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_LINE2:       cfg_d.gain[1]          = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_LINE3:       cfg_d.gain[2]          = cfg_wdata_i[GAIN_W-1:0];
        CFG_LINE_WIRE_MAP:    cfg_d.wire_map         = cfg_wdata_i[MAP_W-1:0];
        CFG_PEAK_FLOOR:       cfg_d.peak_floor       = cfg_wdata_i[PMIN_W-1:0];
        CFG_CONFIDENCE_RATIO: cfg_d.confidence_ratio = cfg_wdata_i[RATIO_W-1:0];
        CFG_WINDOW_MS:        cfg_d.window_ms        = cfg_wdata_i[TIME_W-1:0];
        default:              cfg_d                  = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain[0]          <= GAIN_RESET;
      cfg_q.gain[1]          <= GAIN_RESET;
      cfg_q.gain[2]          <= GAIN_RESET;
      cfg_q.wire_map         <= MAP_RESET;
      cfg_q.peak_floor       <= PMIN_RESET;
      cfg_q.confidence_ratio <= RATIO_RESET;
      cfg_q.window_ms        <= WINDOW_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/pld_accum.sv =====
`default_nettype none

module pld_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pld_pkg::pld_cfg_t   cfg_i,
  pld_frame_if.sink           frame_i,
  output logic                ev_valid_o,
  input  logic                ev_ready_i,
  output pld_pkg::pld_event_t ev_o
);
  import pld_pkg::*;

  // Input register
  logic                            v1_q;
  logic [NUM_LINES-1:0][RAW_W-1:0] raw1_q;
  logic [TIME_W-1:0]               now1_q;

  // Score register
  logic                              v2_q;
  logic [NUM_LINES-1:0][SCORE_W-1:0] prod2_q;
  logic                              ok2_q;
  logic [TIME_W-1:0]                 now2_q;

  // Window state
  logic                            started_q;
  logic [TIME_W-1:0]               wstart_q;
  logic [NUM_LINES-1:0][ACC_W-1:0] acc_q;
  logic [COUNT_W-1:0]              count_q;

  logic                              accept;
  logic                              adv1;
  logic                              adv2;
  logic                              s2_free;
  logic [1:0]                        wire_sel  [NUM_LINES];
  logic [RAW_W-1:0]                  raw_sel   [NUM_LINES];
  logic [RAW_W-1:0]                  mag       [NUM_LINES];
  logic [NUM_LINES-1:0]              mapped;
  logic [NUM_LINES-1:0][SCORE_W-1:0] prod_d;
  logic                              ok_d;
  logic [NUM_LINES-1:0]              hit_line;
  logic                              hit;
  logic [ACC_W:0]                    acc_sum   [NUM_LINES];
  logic [NUM_LINES-1:0][ACC_W-1:0]   acc_new;
  logic [COUNT_W-1:0]                count_new;
  logic [TIME_W-1:0]                 eff_start;
  logic                              elapsed;
  logic                              ev_fire;

  // Handshake: a stage moves when the next one is free
  assign ev_fire       = v2_q & ok2_q & elapsed;
  assign adv2          = v2_q & (~ev_fire | ev_ready_i);
  assign s2_free       = ~v2_q | adv2;
  assign adv1          = v1_q & s2_free;
  assign frame_i.ready = ~v1_q | adv1;
  assign accept        = frame_i.valid & frame_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (frame_i.ready) v1_q <= frame_i.valid;
      if (s2_free)       v2_q <= v1_q;
    end
  end

  // Capture the frame
  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw1_q[0] <= frame_i.raw_power_wire0;
      raw1_q[1] <= frame_i.raw_power_wire1;
      raw1_q[2] <= frame_i.raw_power_wire2;
      now1_q    <= frame_i.now_ms;
    end
  end

  // Per-line score: magnitude of the mapped wire times the line gain
  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      wire_sel[k] = cfg_i.wire_map[2*k +: 2];
      mapped[k]   = (wire_sel[k] != WIRE_NONE);
      unique case (wire_sel[k])
        2'd0:    raw_sel[k] = raw1_q[0];
        2'd1:    raw_sel[k] = raw1_q[1];
        2'd2:    raw_sel[k] = raw1_q[2];
        default: raw_sel[k] = '0;
      endcase
      mag[k]    = raw_sel[k][RAW_W-1] ? (~raw_sel[k] + 1'b1) : raw_sel[k];
      prod_d[k] = mapped[k] ? (SCORE_W'(mag[k]) * SCORE_W'(cfg_i.gain[k])) : '0;
    end
    ok_d = (mapped[0] & mapped[1]) | (mapped[0] & mapped[2]) | (mapped[1] & mapped[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      prod2_q <= prod_d;
      ok2_q   <= ok_d;
      now2_q  <= now1_q;
    end
  end

  // Accumulate when the peak score reaches the minimum, then check the window
  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      hit_line[k] = (prod2_q[k] >= SCORE_W'(cfg_i.peak_floor));
      acc_sum[k]  = {1'b0, acc_q[k]} + (ACC_W+1)'(prod2_q[k]);
    end
    hit = |hit_line;
    for (int k = 0; k < NUM_LINES; k++) begin
      if (!hit)                acc_new[k] = acc_q[k];
      else if (acc_sum[k][ACC_W]) acc_new[k] = '1;
      else                     acc_new[k] = acc_sum[k][ACC_W-1:0];
    end
    count_new = (hit && (count_q != '1)) ? count_q + 1'b1 : count_q;
    eff_start = started_q ? wstart_q : now2_q;
    elapsed   = ((now2_q - eff_start) >= cfg_i.window_ms);
  end

  assign ev_valid_o  = ev_fire;
  assign ev_o.acc      = acc_new;
  assign ev_o.low_load = (count_new == '0);

  // Update the window state as the frame leaves the score register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      wstart_q  <= '0;
      acc_q     <= '0;
      count_q   <= '0;
    end else if (adv2) begin
      started_q <= 1'b1;
      if (!ok2_q) begin
        wstart_q <= eff_start;
      end else if (elapsed) begin
        wstart_q <= now2_q;
        acc_q    <= '0;
        count_q  <= '0;
      end else begin
        wstart_q <= eff_start;
        acc_q    <= acc_new;
        count_q  <= count_new;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pld_decide.sv =====
`default_nettype none

module pld_decide #(
  parameter logic [pld_pkg::STABLE_W-1:0] STABLE_NEEDED = pld_pkg::STABLE_WINDOWS_NEEDED
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pld_pkg::pld_cfg_t   cfg_i,
  input  logic                ev_valid_i,
  output logic                ev_ready_o,
  input  pld_pkg::pld_event_t ev_i,
  pld_result_if.source        result_o
);
  import pld_pkg::*;

  // Window-end register
  logic       v3_q;
  pld_event_t ev3_q;

  // Ranking register
  logic              v4_q;
  logic [ACC_W-1:0]  bs4_q;
  logic [ACC_W-1:0]  ss4_q;
  logic [LINE_W-1:0] best4_q;
  logic [LINE_W-1:0] second4_q;
  logic              low4_q;

  // Partial product register
  logic              v5_q;
  logic [PART_W-1:0] plo5_q;
  logic [PART_W-1:0] phi5_q;
  logic [ACC_W-1:0]  bs5_q;
  logic [LINE_W-1:0] best5_q;
  logic [LINE_W-1:0] second5_q;
  logic              sszero5_q;
  logic              low5_q;

  // Result register and stability state
  logic                ov_q;
  verdict_e            verdict_q;
  logic [LINE_W-1:0]   best_q;
  logic [LINE_W-1:0]   second_q;
  logic [LINE_W-1:0]   stable_line_q;
  logic [STABLE_W-1:0] stable_win_q;

  logic                adv3;
  logic                adv4;
  logic                adv5;
  logic                free3;
  logic                free4;
  logic                free5;
  logic [ACC_W-1:0]    bs_d;
  logic [ACC_W-1:0]    ss_d;
  logic [LINE_W-1:0]   best_d;
  logic [LINE_W-1:0]   second_d;
  logic [PART_W-1:0]   plo_d;
  logic [PART_W-1:0]   phi_d;
  logic [CMP_W-1:0]    rhs;
  logic [CMP_W-1:0]    lhs;
  logic                ambiguous;
  verdict_e            verdict_d;
  logic [LINE_W-1:0]   best_out_d;
  logic [LINE_W-1:0]   second_out_d;
  logic [LINE_W-1:0]   stable_line_d;
  logic [STABLE_W-1:0] stable_win_d;

  // Handshake chain from the result register back to the accumulator
  assign adv5       = v5_q & (~ov_q | result_o.ready);
  assign free5      = ~v5_q | adv5;
  assign adv4       = v4_q & free5;
  assign free4      = ~v4_q | adv4;
  assign adv3       = v3_q & free4;
  assign free3      = ~v3_q | adv3;
  assign ev_ready_o = free3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (free3) v3_q <= ev_valid_i;
      if (free4) v4_q <= v3_q;
      if (free5) v5_q <= v4_q;
      if (adv5)                ov_q <= 1'b1;
      else if (result_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid_i && free3) ev3_q <= ev_i;
  end

  // Rank the accumulated scores; ties keep the lower line as best
  always_comb begin
    if (ev3_q.acc[1] > ev3_q.acc[0]) begin
      best_d   = LINE_L2;
      bs_d     = ev3_q.acc[1];
      second_d = LINE_L1;
      ss_d     = ev3_q.acc[0];
    end else begin
      best_d   = LINE_L1;
      bs_d     = ev3_q.acc[0];
      second_d = LINE_L2;
      ss_d     = ev3_q.acc[1];
    end
    if (ev3_q.acc[2] > bs_d) begin
      second_d = best_d;
      ss_d     = bs_d;
      best_d   = LINE_L3;
      bs_d     = ev3_q.acc[2];
    end else if (ev3_q.acc[2] > ss_d) begin
      second_d = LINE_L3;
      ss_d     = ev3_q.acc[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      bs4_q     <= bs_d;
      ss4_q     <= ss_d;
      best4_q   <= best_d;
      second4_q <= second_d;
      low4_q    <= ev3_q.low_load;
    end
  end

  // Ratio times second score, split into two halves
  assign plo_d = PART_W'(cfg_i.confidence_ratio) * PART_W'(ss4_q[31:0]);
  assign phi_d = PART_W'(cfg_i.confidence_ratio) * PART_W'(ss4_q[ACC_W-1:32]);

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      plo5_q    <= plo_d;
      phi5_q    <= phi_d;
      bs5_q     <= bs4_q;
      best5_q   <= best4_q;
      second5_q <= second4_q;
      sszero5_q <= (ss4_q == '0);
      low5_q    <= low4_q;
    end
  end

  // Combine the halves and compare best * 256 against ratio * second
  assign rhs = {phi5_q, 32'b0} + CMP_W'(plo5_q);
  assign lhs = CMP_W'({bs5_q, 8'b0});

  always_comb begin
    if (sszero5_q) ambiguous = (NO_RATIO_LIMIT < cfg_i.confidence_ratio);
    else           ambiguous = (lhs < rhs);
  end

  // Verdict and stability update
  always_comb begin
    stable_line_d = stable_line_q;
    stable_win_d  = stable_win_q;
    best_out_d    = best5_q;
    second_out_d  = second5_q;
    if (low5_q) begin
      stable_line_d = LINE_NONE;
      stable_win_d  = '0;
      verdict_d     = VERDICT_LOW_LOAD;
      best_out_d    = LINE_L1;
      second_out_d  = LINE_L2;
    end else if (ambiguous) begin
      stable_line_d = LINE_NONE;
      stable_win_d  = '0;
      verdict_d     = VERDICT_AMBIGUOUS;
    end else begin
      if (stable_line_q == best5_q) begin
        if (stable_win_q < STABLE_WINDOWS_MAX) stable_win_d = stable_win_q + 1'b1;
      end else begin
        stable_line_d = best5_q;
        stable_win_d  = STABLE_W'(1);
      end
      verdict_d = (stable_win_d >= STABLE_NEEDED) ? VERDICT_STABLE : VERDICT_WEAK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_line_q <= LINE_NONE;
      stable_win_q  <= '0;
    end else if (adv5) begin
      stable_line_q <= stable_line_d;
      stable_win_q  <= stable_win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      verdict_q <= verdict_d;
      best_q    <= best_out_d;
      second_q  <= second_out_d;
    end
  end

  assign result_o.valid     = ov_q;
  assign result_o.verdict   = verdict_q;
  assign result_o.top_line  = best_q;
  assign result_o.next_line = second_q;

endmodule

`default_nettype wire

// ===== src/phase_line_detector.sv =====
// A closing frame passes input, score, window-end, ranking, partial product, result.
// Throughput: one frame per cycle; the input stalls only when a result waits
// and the four result stages behind the accumulator are all occupied.
// Reset: registers return to their defaults, no window runs, accumulators,
// sample count and stability state are cleared.
`default_nettype none

module phase_line_detector #(
  parameter logic [pld_pkg::STABLE_W-1:0] STABLE_NEEDED = pld_pkg::STABLE_WINDOWS_NEEDED
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pld_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  pld_frame_if.sink                      frame_i,
  pld_result_if.source                   result_o
);
  import pld_pkg::*;

  pld_cfg_t   cfg;
  logic       ev_valid;
  logic       ev_ready;
  pld_event_t ev;

  // Configuration registers
  pld_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Frame scoring and window accumulation
  pld_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .frame_i    (frame_i),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  // Ranking, ratio test and verdict
  pld_decide #(
    .STABLE_NEEDED (STABLE_NEEDED)
  ) u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .ev_valid_i (ev_valid),
    .ev_ready_o (ev_ready),
    .ev_i       (ev),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

// ===== bench/pld_line_checker.sv =====
module pld_line_checker
  import pld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  pld_frame_if                  frame_mon,
  pld_result_if                 result_mon,
  output int unsigned           errors_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    verdict_e          verdict;
    logic [LINE_W-1:0] best;
    logic [LINE_W-1:0] runner_up;
  } line_verdict_t;

  // Shadow of the register file and of the window state
  pld_cfg_t            cfg;
  bit                  win_running;
  logic [TIME_W-1:0]   win_start;
  logic [ACC_W-1:0]    acc [NUM_LINES];
  logic [COUNT_W-1:0]  n_samples;
  logic [LINE_W-1:0]   cand_line;
  logic [STABLE_W-1:0] cand_windows;

  line_verdict_t verdict_q [$];

  // Score one frame; return 1 when it closes a window, with the verdict in res
  function automatic bit judge_frame(input logic [NUM_LINES-1:0][RAW_W-1:0] raw,
                                     input logic [TIME_W-1:0] now,
                                     output line_verdict_t res);
    logic [RAW_W-1:0]   mag;
    logic [SCORE_W-1:0] s [NUM_LINES];
    logic [SCORE_W-1:0] peak;
    logic [1:0]         w;
    int                 mapped;
    logic [ACC_W:0]     sum;
    logic [TIME_W-1:0]  elapsed;
    logic [LINE_W-1:0]  best, runner_up;
    logic [ACC_W-1:0]   bs, ss;
    logic [CMP_W-1:0]   lhs, rhs;
    bit                 ambig;
    res    = '0;
    peak   = '0;
    mapped = 0;
    if (!win_running) begin
      win_start   = now;
      win_running = 1'b1;
    end

    // Score every mapped line from its wire
    for (int k = 0; k < NUM_LINES; k++) begin
      s[k] = '0;
      w    = cfg.wire_map[2*k +: 2];
      if (w != WIRE_NONE) begin
        mag  = raw[w][RAW_W-1] ? (~raw[w] + 1'b1) : raw[w];
        s[k] = SCORE_W'(mag) * SCORE_W'(cfg.gain[k]);
        if (s[k] > peak) peak = s[k];
        mapped++;
      end
    end
    if (mapped < 2) return 1'b0;

    // Accumulate with saturation when the frame is strong enough
    if (peak >= cfg.peak_floor) begin
      for (int k = 0; k < NUM_LINES; k++) begin
        sum    = acc[k] + s[k];
        acc[k] = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      end
      if (n_samples != '1) n_samples++;
    end

    elapsed = now - win_start;
    if (elapsed < cfg.window_ms) return 1'b0;

    if (n_samples == '0) begin
      cand_line    = LINE_NONE;
      cand_windows = '0;
      res          = '{VERDICT_LOW_LOAD, LINE_L1, LINE_L2};
    end else begin
      // Rank the lines, ties keep the lower line ahead
      if (acc[1] > acc[0]) begin
        best = LINE_L2; bs = acc[1]; runner_up = LINE_L1; ss = acc[0];
      end else begin
        best = LINE_L1; bs = acc[0]; runner_up = LINE_L2; ss = acc[1];
      end
      if (acc[2] > bs) begin
        runner_up = best; ss = bs; best = LINE_L3; bs = acc[2];
      end else if (acc[2] > ss) begin
        runner_up = LINE_L3; ss = acc[2];
      end

      // Exact ratio test; an empty runner-up counts as the fixed ratio
      if (ss != '0) begin
        lhs   = {bs, 8'd0};
        rhs   = cfg.confidence_ratio * ss;
        ambig = lhs < rhs;
      end else begin
        ambig = NO_RATIO_LIMIT < cfg.confidence_ratio;
      end

      if (ambig) begin
        cand_line    = LINE_NONE;
        cand_windows = '0;
        res.verdict  = VERDICT_AMBIGUOUS;
      end else begin
        if (cand_line == best) begin
          if (cand_windows != STABLE_WINDOWS_MAX) cand_windows++;
        end else begin
          cand_line    = best;
          cand_windows = 1;
        end
        res.verdict = (cand_windows >= STABLE_WINDOWS_NEEDED) ? VERDICT_STABLE
                                                               : VERDICT_WEAK;
      end
      res.best      = best;
      res.runner_up = runner_up;
    end

    // Restart the window at this frame
    for (int k = 0; k < NUM_LINES; k++) acc[k] = '0;
    n_samples   = '0;
    win_start   = now;
    win_running = 1'b1;
    return 1'b1;
  endfunction

  // Track registers, predict on each frame, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    line_verdict_t fresh;
    line_verdict_t want;
    if (!rst_ni) begin
      cfg.gain             = {NUM_LINES{GAIN_RESET}};
      cfg.wire_map         = MAP_RESET;
      cfg.peak_floor       = PMIN_RESET;
      cfg.confidence_ratio = RATIO_RESET;
      cfg.window_ms        = WINDOW_RESET;
      win_running          = 1'b0;
      win_start            = '0;
      for (int k = 0; k < NUM_LINES; k++) acc[k] = '0;
      n_samples            = '0;
      cand_line            = LINE_NONE;
      cand_windows         = '0;
      verdict_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GAIN_LINE1:       cfg.gain[0]          = cfg_wdata_i[GAIN_W-1:0];
          CFG_GAIN_LINE2:       cfg.gain[1]          = cfg_wdata_i[GAIN_W-1:0];
          CFG_GAIN_LINE3:       cfg.gain[2]          = cfg_wdata_i[GAIN_W-1:0];
          CFG_LINE_WIRE_MAP:    cfg.wire_map         = cfg_wdata_i[MAP_W-1:0];
          CFG_PEAK_FLOOR:       cfg.peak_floor       = cfg_wdata_i[PMIN_W-1:0];
          CFG_CONFIDENCE_RATIO: cfg.confidence_ratio = cfg_wdata_i[RATIO_W-1:0];
          CFG_WINDOW_MS:        cfg.window_ms        = cfg_wdata_i[TIME_W-1:0];
          default: ;
        endcase
      end

      if (frame_mon.valid && frame_mon.ready) begin
        if (judge_frame({frame_mon.raw_power_wire2, frame_mon.raw_power_wire1,
                         frame_mon.raw_power_wire0}, frame_mon.now_ms, fresh))
          verdict_q.push_back(fresh);
      end

      if (result_mon.valid && result_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transaction: verdict %0d top_line %0d next_line %0d",
                 result_mon.verdict, result_mon.top_line, result_mon.next_line);
          errors_o++;
        end else begin
          want = verdict_q.pop_front();
          if (result_mon.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, result_mon.verdict);
            errors_o++;
          end
          if (result_mon.top_line !== want.best) begin
            $error("top_line: expected %0d, actual %0d", want.best, result_mon.top_line);
            errors_o++;
          end
          if (result_mon.next_line !== want.runner_up) begin
            $error("next_line: expected %0d, actual %0d",
                   want.runner_up, result_mon.next_line);
            errors_o++;
          end
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

// ===== bench/tb_phase_line_detector.sv =====
module tb_phase_line_detector;
  import pld_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_FRAMES   = 1500;
  localparam int PRESSURE_FRAMES = 80;
  localparam int SAT_FRAMES      = 600;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  pld_frame_if  frame_if ();
  pld_result_if result_if ();

  int unsigned   fail_count;
  int unsigned   pending;
  int unsigned   quiet_cycles = 0;
  bit            tx_idle_on;
  bit            rx_idle_on;
  bit            hold_req;
  logic [31:0]   now_ms_q;

  phase_line_detector dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .frame_i  (frame_if),
    .result_o (result_if)
  );

  pld_line_checker u_line_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .frame_mon  (frame_if),
    .result_mon (result_if),
    .errors_o   (fail_count),
    .pending_o  (pending)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready) ||
          cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result sink: random stalls, plus one long hold on request
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      result_if.ready <= !rx_idle_on || ($urandom_range(99) >= 20);
    end
  end

  function automatic pld_cfg_t make_cfg(input logic [GAIN_W-1:0] g1, g2, g3,
                                        input logic [MAP_W-1:0] map,
                                        input logic [PMIN_W-1:0] pmin,
                                        input logic [RATIO_W-1:0] ratio,
                                        input logic [TIME_W-1:0] win);
    pld_cfg_t c;
    c.gain[0]          = g1;
    c.gain[1]          = g2;
    c.gain[2]          = g3;
    c.wire_map         = map;
    c.peak_floor       = pmin;
    c.confidence_ratio = ratio;
    c.window_ms        = win;
    return c;
  endfunction

  // Hold one register write for a cycle; the caller lowers the enable
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input pld_cfg_t c);
    write_reg(CFG_GAIN_LINE1, c.gain[0]);
    write_reg(CFG_GAIN_LINE2, c.gain[1]);
    write_reg(CFG_GAIN_LINE3, c.gain[2]);
    write_reg(CFG_LINE_WIRE_MAP, c.wire_map);
    write_reg(CFG_PEAK_FLOOR, c.peak_floor);
    write_reg(CFG_CONFIDENCE_RATIO, c.confidence_ratio);
    write_reg(CFG_WINDOW_MS, c.window_ms);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one frame, with an optional gap first, until it is accepted
  task automatic send_frame(input logic [31:0] r0, r1, r2, input logic [31:0] now);
    int gap;
    gap = (tx_idle_on && $urandom_range(99) < 20) ? $urandom_range(1, 2) : 0;
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    frame_if.valid           <= 1'b1;
    frame_if.raw_power_wire0 <= r0;
    frame_if.raw_power_wire1 <= r1;
    frame_if.raw_power_wire2 <= r2;
    frame_if.now_ms          <= now;
    do @(posedge clk_i); while (!frame_if.ready);
    @(negedge clk_i);
  endtask

  // Mostly one dominant wire with small neighbors, else random or extreme readings
  task automatic send_random_frame(input int dom, input bit tight);
    logic [31:0] r [3];
    int          sel;
    sel = $urandom_range(99);
    for (int w = 0; w < 3; w++) begin
      if (sel < 70) begin
        r[w] = (w == dom) ? $urandom_range(32'h7FFF_FFFF, 32'h0010_0000)
                          : $urandom_range(32'h0001_0000, 0);
        if ($urandom_range(1)) r[w] = -r[w];
      end else if (sel < 90) begin
        r[w] = $urandom();
      end else begin
        case ($urandom_range(4))
          0:       r[w] = 32'h8000_0000;
          1:       r[w] = 32'h7FFF_FFFF;
          2:       r[w] = 32'h0000_0000;
          3:       r[w] = 32'h0000_0001;
          default: r[w] = 32'hFFFF_FFFF;
        endcase
      end
    end
    if (tight) now_ms_q += 1;
    else if ($urandom_range(99) < 90) now_ms_q += $urandom_range(3, 0);
    else now_ms_q = $urandom();
    send_frame(r[0], r[1], r[2], now_ms_q);
  endtask

  // Drop valid, wait for every pending verdict, then let the pipeline settle
  task automatic drain();
    frame_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    pld_cfg_t    c;
    int unsigned sent;
    int          phase;
    int          n;
    int          dom;
    int          mapped;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = '0;
    cfg_wdata_i              = '0;
    frame_if.valid           = 1'b0;
    frame_if.raw_power_wire0 = '0;
    frame_if.raw_power_wire1 = '0;
    frame_if.raw_power_wire2 = '0;
    frame_if.now_ms          = '0;
    tx_idle_on               = 1'b1;
    rx_idle_on               = 1'b1;
    hold_req                 = 1'b0;
    rst_ni                   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single mapped line: frame ignored, but the first window still opens
    apply_config(make_cfg(GAIN_RESET, GAIN_RESET, GAIN_RESET, 6'd62, '0, RATIO_RESET, 10));
    send_frame(1, 2, 3, 50);
    drain();

    // Timestamp zero, extreme readings, then four agreeing windows
    apply_config(make_cfg(GAIN_RESET, GAIN_RESET, GAIN_RESET, MAP_RESET, '0, RATIO_RESET,
                          10));
    send_frame(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_frame(5, -3, 0, 10);
    send_frame(0, 0, 0, 20);
    send_frame(0, 100, 0, 30);
    send_frame(0, 100, 0, 40);
    send_frame(0, 100, 0, 50);
    send_frame(0, 100, 0, 60);
    drain();

    // Max gains, max threshold and ratio: low load, timestamp wrap, empty runner-up
    apply_config(make_cfg(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, MAP_RESET,
                          40'hFF_FFFF_FFFF, 18'h3_FFFF, 5));
    send_frame(1, 1, 1, 32'hFFFF_FFFD);
    send_frame(32'h8000_0000, 0, 5, 2);
    send_frame(0, 0, 0, 3);
    send_frame(0, 0, 0, 7);
    send_frame(32'h7FFF_FFFF, 0, 0, 8);
    send_frame(0, 0, 0, 12);
    drain();

    // Two lines on one wire, third line unmapped, zero gain
    apply_config(make_cfg('0, 24'hFF_FFFF, 1, 6'd48, '0, 18'd256, 1));
    send_frame(7, 9, 9, 100);
    send_frame(-7, 0, 0, 101);
    drain();

    // All lines on one wire: a three-way tie with zero ratio
    apply_config(make_cfg(GAIN_RESET, GAIN_RESET, GAIN_RESET, 6'd0, '0, '0, 1));
    send_frame(3, 0, 0, 102);
    drain();

    // No mapped line at all
    apply_config(make_cfg(GAIN_RESET, GAIN_RESET, GAIN_RESET, 6'd63, '0, RATIO_RESET, 1));
    send_frame(1, 1, 1, 103);
    drain();

    // Random phases, each with its own register setting
    now_ms_q = 200;
    sent     = 0;
    phase    = 0;
    while (sent < RANDOM_FRAMES) begin
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      if (phase == 2) begin
        // Stall the sink long enough to back up the input
        apply_config(make_cfg(GAIN_RESET, GAIN_RESET, GAIN_RESET, MAP_RESET, PMIN_RESET,
                              RATIO_RESET, 1));
        hold_req = 1'b1;
        dom      = $urandom_range(2);
        repeat (PRESSURE_FRAMES) send_random_frame(dom, 1'b1);
        sent += PRESSURE_FRAMES;
      end else if (phase == 4) begin
        // Drive two accumulators into saturation within one window
        apply_config(make_cfg(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, MAP_RESET, '0,
                              18'd256, SAT_FRAMES - 10));
        now_ms_q += 32'h1000_0000;
        repeat (SAT_FRAMES) begin
          now_ms_q += 1;
          send_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000, now_ms_q);
        end
        sent += SAT_FRAMES;
      end else begin
        for (int k = 0; k < NUM_LINES; k++) begin
          case ($urandom_range(9))
            0:       c.gain[k] = '0;
            1:       c.gain[k] = 24'hFF_FFFF;
            2, 3:    c.gain[k] = $urandom_range(24'hFF_FFFF, 0);
            default: c.gain[k] = $urandom_range(70000, 60000);
          endcase
        end
        case ($urandom_range(9))
          7, 8:    c.wire_map = MAP_RESET;
          9:       c.wire_map = $urandom();
          default: c.wire_map = {2'($urandom_range(2)), 2'($urandom_range(2)),
                                 2'($urandom_range(2))};
        endcase
        case ($urandom_range(9))
          5, 6:    c.peak_floor = {8'($urandom()), 32'($urandom())};
          7:       c.peak_floor = 40'hFF_FFFF_FFFF;
          8, 9:    c.peak_floor = {8'd0, 32'($urandom())};
          default: c.peak_floor = '0;
        endcase
        case ($urandom_range(9))
          4:       c.confidence_ratio = '0;
          5, 6:    c.confidence_ratio = $urandom();
          7:       c.confidence_ratio = 18'h3_FFFF;
          8, 9:    c.confidence_ratio = $urandom_range(18'h3_FFFF, NO_RATIO_LIMIT - 4);
          default: c.confidence_ratio = $urandom_range(768, 256);
        endcase
        case ($urandom_range(9))
          6, 7:    c.window_ms = $urandom_range(200, 9);
          8:       c.window_ms = 32'hFFFF_FFFF;
          9:       c.window_ms = $urandom() | 32'h1;
          default: c.window_ms = $urandom_range(8, 1);
        endcase
        apply_config(c);

        mapped = 0;
        for (int k = 0; k < NUM_LINES; k++)
          if (c.wire_map[2*k +: 2] != WIRE_NONE) mapped++;
        n   = $urandom_range(60, 20);
        dom = $urandom_range(2);
        repeat (n) send_random_frame(dom, 1'b0);
        if (mapped >= 2) sent += n;
      end
      drain();
      phase++;
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
